>>> sv/btlv_pkg.sv
`default_nettype none

package btlv_pkg;

    // Default configuration of the level stack.
    localparam int MAX_DEPTH     = 8;
    localparam int POSITION_BITS = 16;

    // Width of the depth counter, fixed by the result field (MAX_DEPTH stays below 16).
    localparam int DEPTH_BITS = 4;

    // Field widths of the stream payloads.
    localparam int BYTE_BITS   = 8;
    localparam int LENGTH_BITS = 7;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 3;

    // Bit fields of the first tag byte and of the length byte.
    localparam logic [7:0] TAG_CLASS_MASK   = 8'hC0;
    localparam logic [7:0] TAG_APPL_BIT     = 8'h40;
    localparam logic [7:0] TAG_CONSTR_MASK  = 8'h20;
    localparam logic [7:0] TAG_NUMBER_MASK  = 8'h1F;
    localparam logic [7:0] LEN_LONG_MASK    = 8'h80;
    localparam logic [7:0] LEN_SHORT_MASK   = 8'h7F;
    localparam logic [7:0] LEN_INDEFINITE   = 8'h80;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_TAG_FIRST = 2'd0,
        PH_TAG_CONT  = 2'd1,
        PH_LENGTH    = 2'd2,
        PH_VALUE     = 2'd3
    } t_phase;

    // Role reported for each byte.
    typedef enum logic [2:0] {
        ROLE_TAG_FIRST = 3'd0,
        ROLE_TAG_CONT  = 3'd1,
        ROLE_LENGTH    = 3'd2,
        ROLE_VALUE     = 3'd3,
        ROLE_IGNORED   = 3'd4
    } t_role;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_INDEFINITE = 3'd1,
        ERR_LONG_FORM  = 3'd2,
        ERR_TRUNCATED  = 3'd3,
        ERR_TOO_DEEP   = 3'd4,
        ERR_OVERRUN    = 3'd5
    } t_err;

    // Control broadcast from the parser to every level cell.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop_en;
    } t_cell_ctrl;

    // Status a level cell hands to its neighbors.
    typedef struct packed {
        logic valid;
        logic pop;
        logic freed;
    } t_cell_stat;

endpackage

`default_nettype wire

>>> sv/ber_tlv_stream_parser_unit.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata = data byte, tlast = last byte
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata = element info, tuser = byte role
//
// A new byte is taken in each cycle in which the output register is empty or is
// being drained. The byte is classified and the level stack compares all end
// positions in parallel in that same cycle.
// Reset is synchronous and active low and clears all parser state at once.
// A stall on the output holds the result and drops o_s_axis_tready.

`default_nettype none

module ber_tlv_stream_parser_unit #(
    parameter int MAX_DEPTH     = btlv_pkg::MAX_DEPTH,
    parameter int POSITION_BITS = btlv_pkg::POSITION_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] data_byte
    input  wire logic [7:0]  i_s_axis_tdata,
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [1:0] tag_class, [2] is_constructed, [6:3] nesting_depth,
    // [13:7] element_length, [14] element_done, [17:15] error_code, [23:18] zero
    output logic [23:0]      o_m_axis_tdata,
    // [2:0] byte_role
    output logic [2:0]       o_m_axis_tuser
);

    localparam int DW = btlv_pkg::DEPTH_BITS;
    localparam int LW = btlv_pkg::LENGTH_BITS;

    // Parser state.
    btlv_pkg::t_phase         r_phase;
    btlv_pkg::t_phase         n_phase;
    logic [POSITION_BITS-1:0] r_pos;
    logic [DW-1:0]            r_open;
    logic [DW-1:0]            n_open;
    logic [LW-1:0]            r_vleft;
    logic [LW-1:0]            n_vleft;
    logic [1:0]               r_class;
    logic [1:0]               n_class;
    logic                     r_cons;
    logic                     n_cons;
    logic [LW-1:0]            r_len;
    logic [LW-1:0]            n_len;
    logic                     r_err;

    // Output register.
    logic                     r_out_valid;
    logic [23:0]              r_out_data;
    logic [2:0]               r_out_user;

    // Per-byte results.
    btlv_pkg::t_role          w_role;
    btlv_pkg::t_err           w_err_pre;
    btlv_pkg::t_err           w_err;
    logic [LW-1:0]            w_len_out;
    logic                     w_done;
    logic [1:0]               w_class_out;
    logic                     w_cons_out;
    logic [DW-1:0]            w_depth_out;
    logic                     w_push;

    logic                     w_accept;
    logic [7:0]               w_byte;
    logic [POSITION_BITS-1:0] w_next;
    logic [POSITION_BITS-1:0] w_end;
    logic [POSITION_BITS-1:0] w_top_end;
    logic [DW-1:0]            w_kept;

    btlv_pkg::t_cell_ctrl     w_ctrl;
    btlv_pkg::t_cell_stat     w_stat     [MAX_DEPTH];
    logic [POSITION_BITS-1:0] w_cell_end [MAX_DEPTH];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_byte          = i_s_axis_tdata;
    assign w_next          = r_pos + POSITION_BITS'(1);
    assign w_end           = w_next + POSITION_BITS'(w_byte & btlv_pkg::LEN_SHORT_MASK);

    // Row of level cells; the freed signal ripples from the top cell downward.
    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_level
        logic w_below_valid;
        logic w_above_valid;
        logic w_above_freed;

        if (g == 0) begin : g_bottom
            assign w_below_valid = 1'b1;
        end else begin : g_inner_below
            assign w_below_valid = w_stat[g-1].valid;
        end

        if (g == MAX_DEPTH - 1) begin : g_top
            assign w_above_valid = 1'b0;
            assign w_above_freed = 1'b1;
        end else begin : g_inner_above
            assign w_above_valid = w_stat[g+1].valid;
            assign w_above_freed = w_stat[g+1].freed;
        end

        btlv_level_cell #(
            .POSITION_BITS(POSITION_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_push_end   (w_end),
            .i_next_pos   (w_next),
            .i_below_valid(w_below_valid),
            .i_above_valid(w_above_valid),
            .i_above_freed(w_above_freed),
            .o_stat       (w_stat[g]),
            .o_top_end    (w_cell_end[g])
        );
    end

    // End of the innermost level and count of levels that stay open.
    always_comb begin
        w_top_end = '0;
        w_kept    = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            w_top_end = w_top_end | w_cell_end[i];
            w_kept    = w_kept + DW'(w_stat[i].valid && !w_stat[i].pop);
        end
    end

    // Byte classification and next parser state.
    always_comb begin
        w_role    = btlv_pkg::ROLE_IGNORED;
        w_err_pre = btlv_pkg::ERR_NONE;
        w_err     = btlv_pkg::ERR_NONE;
        w_len_out = '0;
        w_done    = 1'b0;
        w_push    = 1'b0;
        n_phase   = r_phase;
        n_class   = r_class;
        n_cons    = r_cons;
        n_len     = r_len;
        n_vleft   = r_vleft;
        n_open    = r_open;

        if (!r_err) begin
            // Tag or length byte past the end of the innermost level.
            if (r_phase != btlv_pkg::PH_VALUE && r_open != '0 && r_pos >= w_top_end) begin
                w_err_pre = btlv_pkg::ERR_OVERRUN;
            end

            case (r_phase)
                btlv_pkg::PH_TAG_FIRST: begin
                    w_role  = btlv_pkg::ROLE_TAG_FIRST;
                    n_class = 2'((w_byte & btlv_pkg::TAG_CLASS_MASK) >> 6);
                    n_cons  = (w_byte & btlv_pkg::TAG_CONSTR_MASK) != '0;
                    n_len   = '0;
                    if ((w_byte & btlv_pkg::TAG_NUMBER_MASK) == btlv_pkg::TAG_NUMBER_MASK) begin
                        n_phase = btlv_pkg::PH_TAG_CONT;
                    end else begin
                        n_phase = btlv_pkg::PH_LENGTH;
                    end
                end
                btlv_pkg::PH_TAG_CONT: begin
                    w_role = btlv_pkg::ROLE_TAG_CONT;
                    if ((w_byte & btlv_pkg::LEN_LONG_MASK) == '0) begin
                        n_phase = btlv_pkg::PH_LENGTH;
                    end
                end
                btlv_pkg::PH_LENGTH: begin
                    w_role = btlv_pkg::ROLE_LENGTH;
                    if (w_err_pre != btlv_pkg::ERR_NONE) begin
                        n_phase = r_phase;
                    end else if (w_byte == btlv_pkg::LEN_INDEFINITE) begin
                        w_err_pre = btlv_pkg::ERR_INDEFINITE;
                    end else if ((w_byte & btlv_pkg::LEN_LONG_MASK) != '0) begin
                        w_err_pre = btlv_pkg::ERR_LONG_FORM;
                    end else begin
                        n_len     = LW'(w_byte & btlv_pkg::LEN_SHORT_MASK);
                        w_len_out = n_len;
                        if (r_open != '0 && w_end > w_top_end) begin
                            w_err_pre = btlv_pkg::ERR_OVERRUN;
                        end else if (n_len == '0) begin
                            w_done  = 1'b1;
                            n_phase = btlv_pkg::PH_TAG_FIRST;
                        end else if (r_cons) begin
                            if (r_open == DW'(MAX_DEPTH)) begin
                                w_err_pre = btlv_pkg::ERR_TOO_DEEP;
                            end else begin
                                w_push  = 1'b1;
                                n_phase = btlv_pkg::PH_TAG_FIRST;
                            end
                        end else begin
                            n_vleft = n_len;
                            n_phase = btlv_pkg::PH_VALUE;
                        end
                    end
                end
                default: begin
                    w_role    = btlv_pkg::ROLE_VALUE;
                    w_len_out = r_len;
                    if (r_vleft != '0) begin
                        n_vleft = r_vleft - LW'(1);
                    end
                    if (n_vleft == '0) begin
                        w_done  = 1'b1;
                        n_phase = btlv_pkg::PH_TAG_FIRST;
                    end
                end
            endcase

            // Level count after a push or after closing levels.
            if (w_push) begin
                n_open = r_open + DW'(1);
            end else if (n_phase == btlv_pkg::PH_TAG_FIRST) begin
                n_open = w_kept;
            end

            // Truncation check on the last byte.
            w_err = w_err_pre;
            if (w_err_pre == btlv_pkg::ERR_NONE && i_s_axis_tlast &&
                !(n_phase == btlv_pkg::PH_TAG_FIRST && n_open == '0)) begin
                w_err = btlv_pkg::ERR_TRUNCATED;
            end
            if (w_err != btlv_pkg::ERR_NONE) begin
                w_done = 1'b0;
            end
        end
    end

    // Fields reported for the byte; an ignored byte reports only its role.
    assign w_class_out = r_err ? 2'b00 : n_class;
    assign w_cons_out  = r_err ? 1'b0 : n_cons;
    assign w_depth_out = r_err ? '0 : r_open;

    // Stack control for the accepted byte.
    assign w_ctrl.clear  = w_accept && i_s_axis_tlast;
    assign w_ctrl.push   = w_accept && w_push && w_err_pre == btlv_pkg::ERR_NONE;
    assign w_ctrl.pop_en = w_accept && !r_err && w_err_pre == btlv_pkg::ERR_NONE &&
                           !w_push && n_phase == btlv_pkg::PH_TAG_FIRST;

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= btlv_pkg::PH_TAG_FIRST;
            r_pos   <= '0;
            r_open  <= '0;
            r_vleft <= '0;
            r_class <= '0;
            r_cons  <= 1'b0;
            r_len   <= '0;
            r_err   <= 1'b0;
        end else if (w_accept) begin
            if (i_s_axis_tlast) begin
                r_phase <= btlv_pkg::PH_TAG_FIRST;
                r_pos   <= '0;
                r_open  <= '0;
                r_vleft <= '0;
                r_class <= '0;
                r_cons  <= 1'b0;
                r_len   <= '0;
                r_err   <= 1'b0;
            end else if (!r_err) begin
                if (w_err != btlv_pkg::ERR_NONE) begin
                    r_err <= 1'b1;
                end else begin
                    r_phase <= n_phase;
                    r_pos   <= w_next;
                    r_open  <= n_open;
                    r_vleft <= n_vleft;
                    r_class <= n_class;
                    r_cons  <= n_cons;
                    r_len   <= n_len;
                end
            end
        end
    end

    // Output register: loaded on each input transaction, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {6'b000000, w_err, w_done, w_len_out, w_depth_out,
                           w_cons_out, w_class_out};
            r_out_user <= w_role;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

>>> sv/btlv_level_cell.sv
`default_nettype none

// One level of the nesting stack: holds the end position of an open
// constructed element and decides, with its neighbors, whether it closes.
module btlv_level_cell #(
    parameter int POSITION_BITS = btlv_pkg::POSITION_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire btlv_pkg::t_cell_ctrl     i_ctrl,
    input  wire logic [POSITION_BITS-1:0] i_push_end,
    input  wire logic [POSITION_BITS-1:0] i_next_pos,
    input  wire logic                     i_below_valid,
    input  wire logic                     i_above_valid,
    input  wire logic                     i_above_freed,
    output btlv_pkg::t_cell_stat          o_stat,
    output logic [POSITION_BITS-1:0]      o_top_end
);

    logic                     r_valid;
    logic                     n_valid;
    logic [POSITION_BITS-1:0] r_end;
    logic                     w_pop;
    logic                     w_push_here;

    // A level closes when it ends at the next position and every level above is gone.
    assign w_pop       = r_valid && (r_end == i_next_pos) && i_above_freed && i_ctrl.pop_en;
    assign w_push_here = i_ctrl.push && !r_valid && i_below_valid;

    assign o_stat.valid = r_valid;
    assign o_stat.pop   = w_pop;
    assign o_stat.freed = !r_valid || w_pop;

    // Only the innermost open level drives its end position.
    assign o_top_end = (r_valid && !i_above_valid) ? r_end : '0;

    // Next state of the valid bit.
    always_comb begin
        n_valid = r_valid;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (w_push_here) begin
            n_valid = 1'b1;
        end else if (w_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // End position, written on push.
    always_ff @(posedge i_clk) begin
        if (w_push_here && !i_ctrl.clear) begin
            r_end <= i_push_end;
        end
    end

endmodule

`default_nettype wire

>>> sv/btlv_stream_checker.sv
`default_nettype none

// Port-level checks of the parser's result stream.
module btlv_stream_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata,
    input wire logic [2:0]  o_m_axis_tuser
);

    // A result that is not taken stays and holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("Stalled result changed or vanished.");

    // A full output register that is not drained blocks the input side.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("Input accepted while the result register was stalled.");

    // An ignored byte reports nothing but its role.
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == btlv_pkg::ROLE_IGNORED |->
            o_m_axis_tdata == 24'd0)
        else $error("Ignored byte carries element fields.");

    // A byte with an error never completes an element.
    a_err_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[17:15] != btlv_pkg::ERR_NONE |->
            !o_m_axis_tdata[14])
        else $error("Element completed on an error byte.");

    // Only length and value bytes complete an element.
    a_done_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[14] |->
            o_m_axis_tuser == btlv_pkg::ROLE_LENGTH || o_m_axis_tuser == btlv_pkg::ROLE_VALUE)
        else $error("Element completed on a tag byte.");

endmodule

bind ber_tlv_stream_parser_unit btlv_stream_checker u_btlv_stream_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);

`default_nettype wire
